// ----- rtl/core/dbf_pkg.sv -----
// Shared types, constants and fixed-point helpers of the damped bond force block.
package dbf_pkg;

    // Number of spatial dimensions (2 or 3)
    localparam int DIMENSIONS = 3;

    // Pipeline depths of the iterative units, one bit per stage
    localparam int SQRT_LAT = 32;
    localparam int DIV_LAT  = 41;

    // Register index decoded from paddr[2]
    localparam logic [0:0] REG_DAMPING = 1'b0;

    localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

    // Clamp for the rate quotient (d.v)/r
    localparam logic [DIV_LAT-1:0] Q1_CLAMP = DIV_LAT'(1) << (DIV_LAT - 1);

    // One bond
    typedef struct packed {
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
        logic signed [31:0] relv_x;
        logic signed [31:0] relv_y;
        logic signed [31:0] relv_z;
        logic [30:0]        rest_length;
        logic [30:0]        owner_modulus;
        logic [30:0]        neighbour_modulus;
        logic [30:0]        force_scaling;
        logic [30:0]        neighbour_volume;
        logic [30:0]        volume_scaling;
    } t_bond_in;

    // Force, stretch and stress of one bond
    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] stretch;
        logic signed [31:0] stress_xx;
        logic signed [31:0] stress_yy;
        logic signed [31:0] stress_xy;
        logic signed [31:0] stress_zz;
        logic signed [31:0] stress_xz;
        logic signed [31:0] stress_yz;
    } t_bond_out;

    // Divider result: quotient, overflow (quotient too wide or divide by zero), numerator nonzero
    typedef struct packed {
        logic [DIV_LAT-1:0] q;
        logic               ovf;
        logic               nz;
    } t_div_res;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // Signed saturation of a sign and a magnitude
    function automatic logic signed [31:0] satq(input logic neg, input logic [63:0] mag);
        logic signed [31:0] res;
        if (neg) begin
            if (mag >= 64'h8000_0000) res = SAT_NEG;
            else res = -$signed(mag[31:0]);
        end else begin
            if (mag > 64'h7FFF_FFFF) res = SAT_POS;
            else res = $signed(mag[31:0]);
        end
        return res;
    endfunction

    // Sign-magnitude product, truncated toward zero, shift 16 or 17
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic sh17);
        logic [63:0] p;
        p = 64'(mag32(a)) * 64'(mag32(b));
        p = sh17 ? (p >> 17) : (p >> 16);
        return satq(a[31] ^ b[31], p);
    endfunction

    // Saturated quotient from a divider result
    function automatic logic signed [31:0] divsat(input logic neg, input t_div_res dr);
        logic signed [31:0] res;
        if (!dr.nz) res = '0;
        else if (dr.ovf) res = satq(neg, 64'h8000_0000);
        else res = satq(neg, 64'(dr.q));
        return res;
    endfunction

endpackage

// ----- rtl/core/dbf_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module dbf_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);
    localparam int N = dbf_pkg::SQRT_LAT;

    logic [63:0] r_x    [N];
    logic [33:0] r_rem  [N];
    logic [31:0] r_root [N];

    logic [63:0] n_x    [N];
    logic [33:0] n_rem  [N];
    logic [31:0] n_root [N];
    logic [63:0] w_x_in    [N];
    logic [33:0] w_rem_in  [N];
    logic [31:0] w_root_in [N];
    logic [35:0] w_t     [N];
    logic [35:0] w_trial [N];

    // One digit step per stage
    always_comb begin
        w_x_in[0]    = i_x;
        w_rem_in[0]  = '0;
        w_root_in[0] = '0;
        for (int k = 1; k < N; k++) begin
            w_x_in[k]    = r_x[k-1];
            w_rem_in[k]  = r_rem[k-1];
            w_root_in[k] = r_root[k-1];
        end
        for (int k = 0; k < N; k++) begin
            w_t[k]     = {w_rem_in[k], w_x_in[k][63:62]};
            w_trial[k] = {2'b00, w_root_in[k], 2'b01};
            n_x[k]     = {w_x_in[k][61:0], 2'b00};
            if (w_t[k] >= w_trial[k]) begin
                n_rem[k]  = 34'(w_t[k] - w_trial[k]);
                n_root[k] = {w_root_in[k][30:0], 1'b1};
            end else begin
                n_rem[k]  = w_t[k][33:0];
                n_root[k] = {w_root_in[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_x[k]    <= n_x[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

// ----- rtl/core/dbf_div.sv -----
// Pipelined restoring divider, 64 by 32 bits, one quotient bit per stage.
module dbf_div (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [63:0]       i_num,
    input  logic [31:0]       i_den,
    output dbf_pkg::t_div_res o_res
);
    localparam int N = dbf_pkg::DIV_LAT;

    logic [31:0]  r_rem [N];
    logic [31:0]  r_den [N];
    logic [N-1:0] r_nq  [N];
    logic [N-1:0] r_ovf;
    logic [N-1:0] r_nz;

    logic [31:0]  n_rem    [N];
    logic [N-1:0] n_nq     [N];
    logic [31:0]  w_rem_in [N];
    logic [31:0]  w_den_in [N];
    logic [N-1:0] w_nq_in  [N];
    logic [32:0]  w_t      [N];

    // Shift in one numerator bit, subtract where it fits
    always_comb begin
        w_rem_in[0] = 32'(i_num[63:N]);
        w_den_in[0] = i_den;
        w_nq_in[0]  = i_num[N-1:0];
        for (int k = 1; k < N; k++) begin
            w_rem_in[k] = r_rem[k-1];
            w_den_in[k] = r_den[k-1];
            w_nq_in[k]  = r_nq[k-1];
        end
        for (int k = 0; k < N; k++) begin
            w_t[k] = {w_rem_in[k], w_nq_in[k][N-1]};
            if (w_t[k] >= {1'b0, w_den_in[k]}) begin
                n_rem[k] = 32'(w_t[k] - {1'b0, w_den_in[k]});
                n_nq[k]  = {w_nq_in[k][N-2:0], 1'b1};
            end else begin
                n_rem[k] = w_t[k][31:0];
                n_nq[k]  = {w_nq_in[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quotient wider than N bits, or divide by zero
            r_ovf[0] <= (32'(i_num[63:N]) >= i_den);
            r_nz[0]  <= (i_num != '0);
            for (int k = 1; k < N; k++) begin
                r_ovf[k] <= r_ovf[k-1];
                r_nz[k]  <= r_nz[k-1];
            end
            for (int k = 0; k < N; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= w_den_in[k];
                r_nq[k]  <= n_nq[k];
            end
        end
    end

    assign o_res.q   = r_nq[N-1];
    assign o_res.ovf = r_ovf[N-1];
    assign o_res.nz  = r_nz[N-1];

endmodule

// ----- rtl/core/dampened_bond_force.sv -----
// Throughput: one item per cycle while o_stall is low; the depth comes from the
// 32-stage square root and three rows of 41-stage dividers (four dividers), one result
// bit per stage.
// An output register plus one skid entry follow the pipeline; o_stall is the skid full flag.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears r_damp.
module dampened_bond_force (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dbf_pkg::t_bond_in  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output dbf_pkg::t_bond_out o_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int LS = dbf_pkg::SQRT_LAT;
    localparam int LD = dbf_pkg::DIV_LAT;

    // Products stage
    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [30:0]        r0;
        logic [30:0]        vol;
        logic [30:0]        vsc;
        logic signed [31:0] cm;
        logic [2:0][63:0]   sq;
        logic [2:0][63:0]   pr;
        logic [2:0]         prn;
    } t_prod;

    // Work carried down the pipeline
    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [30:0]        r0;
        logic signed [31:0] cm;
        logic [30:0]        vol;
        logic [30:0]        vsc;
        logic [63:0]        pos;
        logic [63:0]        neg;
        logic [31:0]        r;
        logic               rzero;
        logic               pneg;
        logic [63:0]        pmag;
        logic               sdn;
        logic [31:0]        sdiff;
        logic signed [31:0] s;
        logic [LD-1:0]      q1;
        logic signed [31:0] dsdt;
        logic signed [31:0] sb;
        logic signed [31:0] a;
        logic signed [31:0] f;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
    } t_work;

    logic w_adv;

    // Configuration register
    logic [30:0] r_damp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp <= '0;
        end else if (psel && penable && pwrite && paddr[2] == dbf_pkg::REG_DAMPING) begin
            r_damp <= pwdata[30:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dbf_pkg::REG_DAMPING) ? {1'b0, r_damp} : '0;

    // Pipeline registers
    dbf_pkg::t_bond_in r_a;
    dbf_pkg::t_bond_in w_in;
    t_prod             r_b, n_b;
    t_work             r_c, n_c;
    logic [63:0]       r_c_r2, n_c_r2;
    t_work             r_l1 [LS];
    t_work             r_e, n_e;
    t_work             r_l2 [LD];
    t_work             r_f, n_f;
    t_work             r_l3 [LD];
    t_work             r_h, n_h, r_i, n_i, r_j, n_j, r_k, n_k, r_l, n_l, r_m, n_m;
    t_work             r_l4 [LD];
    t_work             r_o, n_o, r_p, n_p;
    dbf_pkg::t_bond_out r_q, n_q;

    logic r_va, r_vb, r_vc, r_ve, r_vf, r_vh, r_vi, r_vj, r_vk, r_vl, r_vm;
    logic r_vo, r_vp, r_vq;
    logic [LS-1:0] r_vl1;
    logic [LD-1:0] r_vl2, r_vl3, r_vl4;

    logic [31:0]        w_root;
    dbf_pkg::t_div_res  w_ds, w_dq, w_dd, w_df;
    logic [30:0]        w_mean;
    logic signed [31:0] w_d [3];
    logic signed [31:0] w_v [3];
    logic signed [32:0] w_sum;
    logic [32:0]        w_smag;

    // Iterative units
    dbf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (r_c_r2),
        .o_root (w_root)
    );

    dbf_div u_div_s (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({16'b0, r_e.sdiff, 16'b0}),
        .i_den ({1'b0, r_e.r0}),
        .o_res (w_ds)
    );

    dbf_div u_div_q (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_e.pmag),
        .i_den (r_e.r),
        .o_res (w_dq)
    );

    dbf_div u_div_d (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({(48 - LD)'(0), r_f.q1, 16'b0}),
        .i_den ({1'b0, r_f.r0}),
        .o_res (w_dd)
    );

    dbf_div u_div_f (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({16'b0, dbf_pkg::mag32(r_m.a), 16'b0}),
        .i_den (r_m.r),
        .o_res (w_df)
    );

    // Incoming item, z components dropped in two dimensions
    always_comb begin
        w_in = i_item;
        if (dbf_pkg::DIMENSIONS < 3) begin
            w_in.rel_z  = '0;
            w_in.relv_z = '0;
        end
    end

    // Squares, dot products and modulus scaling
    always_comb begin
        w_d[0] = r_a.rel_x;
        w_d[1] = r_a.rel_y;
        w_d[2] = r_a.rel_z;
        w_v[0] = r_a.relv_x;
        w_v[1] = r_a.relv_y;
        w_v[2] = r_a.relv_z;
        n_b     = '0;
        n_b.dx  = r_a.rel_x;
        n_b.dy  = r_a.rel_y;
        n_b.dz  = r_a.rel_z;
        n_b.r0  = r_a.rest_length;
        n_b.vol = r_a.neighbour_volume;
        n_b.vsc = r_a.volume_scaling;
        w_mean  = 31'((32'(r_a.owner_modulus) + 32'(r_a.neighbour_modulus)) >> 1);
        n_b.cm  = dbf_pkg::mulq($signed({1'b0, w_mean}),
                                $signed({1'b0, r_a.force_scaling}), 1'b0);
        for (int i = 0; i < 3; i++) begin
            n_b.sq[i]  = 64'(dbf_pkg::mag32(w_d[i])) * 64'(dbf_pkg::mag32(w_d[i]));
            n_b.pr[i]  = 64'(dbf_pkg::mag32(w_d[i])) * 64'(dbf_pkg::mag32(w_v[i]));
            n_b.prn[i] = w_d[i][31] ^ w_v[i][31];
        end
    end

    // Sums of squares and of signed products
    always_comb begin
        n_c     = '0;
        n_c.dx  = r_b.dx;
        n_c.dy  = r_b.dy;
        n_c.dz  = r_b.dz;
        n_c.r0  = r_b.r0;
        n_c.cm  = r_b.cm;
        n_c.vol = r_b.vol;
        n_c.vsc = r_b.vsc;
        n_c_r2  = r_b.sq[0] + r_b.sq[1] + r_b.sq[2];
        for (int i = 0; i < 3; i++) begin
            if (r_b.prn[i]) n_c.neg = n_c.neg + r_b.pr[i];
            else n_c.pos = n_c.pos + r_b.pr[i];
        end
    end

    // Length, stretch numerator and sign of d.v
    always_comb begin
        n_e       = r_l1[LS-1];
        n_e.r     = w_root;
        n_e.rzero = (w_root == '0);
        n_e.pneg  = n_e.neg > n_e.pos;
        n_e.pmag  = n_e.pneg ? (n_e.neg - n_e.pos) : (n_e.pos - n_e.neg);
        n_e.sdn   = w_root < 32'(n_e.r0);
        n_e.sdiff = n_e.sdn ? (32'(n_e.r0) - w_root) : (w_root - 32'(n_e.r0));
    end

    // Stretch and clamped rate quotient
    always_comb begin
        n_f   = r_l2[LD-1];
        n_f.s = dbf_pkg::divsat(n_f.sdn, w_ds);
        if (w_dq.ovf || w_dq.q > dbf_pkg::Q1_CLAMP) n_f.q1 = dbf_pkg::Q1_CLAMP;
        else n_f.q1 = w_dq.q;
    end

    // Stretch rate, damping and force factor chain
    always_comb begin
        n_h      = r_l3[LD-1];
        n_h.dsdt = dbf_pkg::divsat(n_h.pneg, w_dd);
        n_i      = r_h;
        n_i.sb   = dbf_pkg::mulq($signed({1'b0, r_damp}), r_h.dsdt, 1'b0);
        w_sum    = 33'(r_i.s) + 33'(r_i.sb);
        w_smag   = w_sum[32] ? (~w_sum + 33'd1) : w_sum;
        n_j      = r_i;
        n_j.sb   = dbf_pkg::satq(w_sum[32], 64'(w_smag));
        n_k      = r_j;
        n_k.a    = dbf_pkg::mulq(r_j.cm, r_j.sb, 1'b0);
        n_l      = r_k;
        n_l.a    = dbf_pkg::mulq(r_k.a, $signed({1'b0, r_k.vol}), 1'b0);
        n_m      = r_l;
        n_m.a    = dbf_pkg::mulq(r_l.a, $signed({1'b0, r_l.vsc}), 1'b0);
    end

    // Force factor, force and stress terms
    always_comb begin
        n_o   = r_l4[LD-1];
        n_o.f = n_o.rzero ? '0 : dbf_pkg::divsat(n_o.a[31], w_df);
        n_p    = r_o;
        n_p.fx = dbf_pkg::mulq(r_o.dx, r_o.f, 1'b0);
        n_p.fy = dbf_pkg::mulq(r_o.dy, r_o.f, 1'b0);
        n_p.fz = dbf_pkg::mulq(r_o.dz, r_o.f, 1'b0);
        n_q.force_x   = r_p.fx;
        n_q.force_y   = r_p.fy;
        n_q.force_z   = r_p.fz;
        n_q.stretch   = r_p.s;
        n_q.stress_xx = dbf_pkg::mulq(r_p.fx, r_p.dx, 1'b1);
        n_q.stress_yy = dbf_pkg::mulq(r_p.fy, r_p.dy, 1'b1);
        n_q.stress_xy = dbf_pkg::mulq(r_p.fx, r_p.dy, 1'b1);
        n_q.stress_zz = dbf_pkg::mulq(r_p.fz, r_p.dz, 1'b1);
        n_q.stress_xz = dbf_pkg::mulq(r_p.fx, r_p.dz, 1'b1);
        n_q.stress_yz = dbf_pkg::mulq(r_p.fy, r_p.dz, 1'b1);
    end

    // Payload registers, all moving together
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a    <= w_in;
            r_b    <= n_b;
            r_c    <= n_c;
            r_c_r2 <= n_c_r2;
            r_l1[0] <= r_c;
            for (int k = 1; k < LS; k++) r_l1[k] <= r_l1[k-1];
            r_e <= n_e;
            r_l2[0] <= r_e;
            for (int k = 1; k < LD; k++) r_l2[k] <= r_l2[k-1];
            r_f <= n_f;
            r_l3[0] <= r_f;
            for (int k = 1; k < LD; k++) r_l3[k] <= r_l3[k-1];
            r_h <= n_h;
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
            r_l <= n_l;
            r_m <= n_m;
            r_l4[0] <= r_m;
            for (int k = 1; k < LD; k++) r_l4[k] <= r_l4[k-1];
            r_o <= n_o;
            r_p <= n_p;
            r_q <= n_q;
        end
    end

    // Valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_va, r_vb, r_vc, r_ve, r_vf, r_vh, r_vi} <= '0;
            {r_vj, r_vk, r_vl, r_vm, r_vo, r_vp, r_vq} <= '0;
            r_vl1 <= '0;
            r_vl2 <= '0;
            r_vl3 <= '0;
            r_vl4 <= '0;
        end else if (w_adv) begin
            r_va  <= i_valid;
            r_vb  <= r_va;
            r_vc  <= r_vb;
            r_vl1 <= {r_vl1[LS-2:0], r_vc};
            r_ve  <= r_vl1[LS-1];
            r_vl2 <= {r_vl2[LD-2:0], r_ve};
            r_vf  <= r_vl2[LD-1];
            r_vl3 <= {r_vl3[LD-2:0], r_vf};
            r_vh  <= r_vl3[LD-1];
            r_vi  <= r_vh;
            r_vj  <= r_vi;
            r_vk  <= r_vj;
            r_vl  <= r_vk;
            r_vm  <= r_vl;
            r_vl4 <= {r_vl4[LD-2:0], r_vm};
            r_vo  <= r_vl4[LD-1];
            r_vp  <= r_vo;
            r_vq  <= r_vp;
        end
    end

    // Output register with one skid entry
    dbf_pkg::t_bond_out r_out, r_skid;
    logic               r_out_v, r_skid_v;
    logic               w_out_free;

    assign w_adv      = !r_skid_v;
    assign w_out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            r_out_v  <= r_skid_v || r_vq;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v && r_vq) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_v ? r_skid : r_q;
        end else if (!r_skid_v) begin
            r_skid <= r_q;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;
    assign o_stall = r_skid_v;

`ifndef ASSERT_OFF
    // Skid holds an item only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry full while output register empty");

    // Skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid filled without output stall");

    // Register write lands
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[2] == dbf_pkg::REG_DAMPING)
        |=> r_damp == $past(pwdata[30:0]))
        else $error("damping register write lost");
`endif

endmodule
